@@ hw/rtl/fqd_pkg.sv @@
package fqd_pkg;

    // Queue geometry.
    localparam int DEPTH = 16;
    localparam int WIDTH = 32;

    // Port field widths.
    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int DOUT_W  = 32;
    localparam int LEN_W   = 5;

    // The count must be able to hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_DEL = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NULL     = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    // Control that the top level broadcasts to every cell.
    typedef struct packed {
        logic compare_en;
        logic use_match;
        logic shift_en;
        logic write_en;
    } cell_ctl_t;

endpackage

@@ hw/rtl/fqd_cell.sv @@
module fqd_cell
    import fqd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic             slot_valid,
    input  logic             slot_sel,
    input  logic [WIDTH-1:0] cmp_word,
    input  logic [WIDTH-1:0] wr_word,
    input  logic [WIDTH-1:0] right_data,
    input  logic             hit_in,
    output logic             hit_out,
    output logic [WIDTH-1:0] data
);

    logic [WIDTH-1:0] data_reg;
    logic             match_reg;
    logic             match_next;
    logic             take_right;

    // A cell moves up once the removed entry is at or ahead of it.
    assign hit_out    = hit_in | (match_reg & ctl.use_match);
    assign take_right = ctl.shift_en & hit_out;
    assign match_next = ctl.compare_en ? (slot_valid && (data_reg == cmp_word)) : match_reg;
    assign data       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_right)
        begin
            data_reg <= right_data;
        end
        else if (ctl.write_en && slot_sel)
        begin
            data_reg <= wr_word;
        end
    end

endmodule

@@ hw/rtl/fifo_queue_with_delete.sv @@
// First-in first-out queue of data words with delete by value.
// Input channel (in_valid, in_stall, cmd, value): cmd selects enqueue at the
// tail, dequeue of the head, or removal of the oldest entry equal to value.
// A value of zero is a null word and is refused by enqueue and delete.
// Output channel (out_valid, out_stall, status, data_out, length): exactly one
// result transfer for every input transfer, in order.
// Storage is a row of identical cells, head in cell zero. In the cycle of an
// input transfer every cell compares its word with value. In the next cycle a
// hit chain runs from the head toward the tail, and every cell at or behind
// the removed entry takes the word of its right neighbor, closing the gap.
// An item therefore passes through the compare cycle and then the chain cycle.
// The result is registered when the chain cycle completes; no new item is
// accepted until then.
// When the receiver stalls, the result register holds; the next item may still
// be taken and compared, but it waits before the chain cycle until the held
// result has been transferred.
// Reset empties the queue and clears all handshake state; the cell words are
// not cleared and are never read before they are written.
module fifo_queue_with_delete
    import fqd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [STAT_W-1:0]  status,
    output logic [DOUT_W-1:0]  data_out,
    output logic [LEN_W-1:0]   length
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [WIDTH-1:0]   word_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [STAT_W-1:0]  status_reg;
    logic [DOUT_W-1:0]  data_out_reg;
    logic [LEN_W-1:0]   length_reg;

    logic               accept;
    logic               commit;
    logic               word_null;
    logic               enq_ok;
    logic               rm_ok;
    status_t            res_status;
    logic [DOUT_W-1:0]  res_data;
    cell_ctl_t          ctl;

    logic [WIDTH-1:0]   cell_data [DEPTH];
    logic [DEPTH:0]     hit;

    // One item at a time: the block accepts only while no item is being executed.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // The chain cycle completes only if the result register can take the result.
    assign commit   = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);

    assign word_null = (word_reg == '0);

    // A dequeue removes the head, so the chain is started at cell zero.
    assign hit[0] = (cmd_reg == CMD_DEQ);

    always_comb
    begin
        enq_ok     = 1'b0;
        rm_ok      = 1'b0;
        res_status = STAT_NULL;
        res_data   = '0;
        case (cmd_reg)
            CMD_ENQ:
            begin
                if (word_null)
                begin
                    res_status = STAT_NULL;
                end
                else if (count_reg == CNT_W'(DEPTH))
                begin
                    res_status = STAT_FULL;
                end
                else
                begin
                    enq_ok     = 1'b1;
                    res_status = STAT_OK;
                end
            end
            CMD_DEQ:
            begin
                if (count_reg != '0)
                begin
                    rm_ok      = 1'b1;
                    res_status = STAT_OK;
                    res_data   = DOUT_W'(cell_data[0]);
                end
            end
            CMD_DEL:
            begin
                if (word_null)
                begin
                    res_status = STAT_NULL;
                end
                else if (hit[DEPTH])
                begin
                    rm_ok      = 1'b1;
                    res_status = STAT_OK;
                end
                else
                begin
                    res_status = STAT_NOTFOUND;
                end
            end
            default:
            begin
                res_status = STAT_NULL;
            end
        endcase
    end

    always_comb
    begin
        ctl.compare_en = accept;
        ctl.use_match  = (cmd_reg == CMD_DEL);
        ctl.shift_en   = commit && rm_ok;
        ctl.write_en   = commit && enq_ok;
    end

    always_comb
    begin
        count_next = count_reg;
        if (commit && enq_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (commit && rm_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    assign out_valid_next = commit || (out_valid_reg && out_stall);

    // Row of cells; cell i is occupied while i is below the count.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WIDTH-1:0] right_word;

        if (i == DEPTH - 1)
        begin : g_last
            assign right_word = '0;
        end
        else
        begin : g_mid
            assign right_word = cell_data[i+1];
        end

        fqd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .slot_valid (CNT_W'(i) < count_reg),
            .slot_sel   (CNT_W'(i) == count_reg),
            .cmp_word   (value[WIDTH-1:0]),
            .wr_word    (word_reg),
            .right_data (right_word),
            .hit_in     (hit[i]),
            .hit_out    (hit[i+1]),
            .data       (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            word_reg <= value[WIDTH-1:0];
        end
        if (commit)
        begin
            status_reg   <= res_status;
            data_out_reg <= res_data;
            length_reg   <= LEN_W'(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_out_reg;
    assign length    = length_reg;

endmodule

@@ hw/rtl/fqd_checker.sv @@
module fqd_checker
    import fqd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [STAT_W-1:0]  status,
    input logic [DOUT_W-1:0]  data_out,
    input logic [LEN_W-1:0]   length
);

    // The queue never reports more entries than it has cells.
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (length <= LEN_W'(DEPTH)))
        else $error("length beyond queue depth");

    // A full report comes only from a full queue.
    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_FULL)) |-> (length == LEN_W'(DEPTH)))
        else $error("full status with queue not full");

    // Only a successful dequeue returns a word.
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (data_out != '0)) |-> (status == STAT_OK))
        else $error("word returned by a failed operation");

    // After an input transfer the block works on that item before taking another.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item taken while one is pending");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) &&
                                      $stable(data_out) && $stable(length)))
        else $error("stalled result changed");

endmodule

bind fifo_queue_with_delete fqd_checker u_fqd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data_out  (data_out),
    .length    (length)
);

@@ tb/sv/tb_fifo_queue_with_delete.sv @@
`timescale 1ns / 1ps

module tb_fifo_queue_with_delete;
    import fqd_pkg::*;

    // The package names only the three real operations. Code three is unused
    // by the block and must be answered with the null status.
    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

    // Cycles without any transfer on either side before the run is declared hung.
    // The longest correct stretch is a receiver hold-off of HOLD_CYCLES plus
    // random stalls, so this leaves a wide margin.
    localparam int STUCK_LIMIT  = 2000;
    // After the last result the bench keeps watching, so that a stray extra
    // result is still caught.
    localparam int TAIL_CYCLES  = 8;
    localparam int HOLD_CYCLES  = 90;
    localparam int RANDOM_ITEMS = 1100;
    localparam int POOL_SIZE    = 6;
    // Items are split into three idling phases of about this many items each.
    localparam int PHASE_SPAN   = 380;
    localparam int DRAIN_EVERY  = 250;

    // One operation waiting to be offered to the block. When wait_drain is
    // set, the driver holds it back until every result due has arrived.
    typedef struct {
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] word;
        bit                 wait_drain;
        int                 phase;
    } queue_op_t;

    typedef struct {
        status_t            status;
        logic [DOUT_W-1:0]  data_out;
        logic [LEN_W-1:0]   length;
    } queue_result_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   cmd       = '0;
    logic [VALUE_W-1:0] value     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [STAT_W-1:0]  status;
    logic [DOUT_W-1:0]  data_out;
    logic [LEN_W-1:0]   length;

    fifo_queue_with_delete u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .data_out  (data_out),
        .length    (length)
    );

    always #10 clk = ~clk;

    // Idle rates in percent per phase. The sender idles less than the
    // receiver first, then the other way round, and the last phase runs flat out.
    int sender_idle_pct[3]   = '{35, 62, 0};
    int receiver_idle_pct[3] = '{62, 35, 0};

    queue_op_t          op_backlog[$];
    queue_result_t      due_results[$];
    logic [VALUE_W-1:0] word_pool[POOL_SIZE];
    bit                 hold_for_drain = 1'b0;

    // Our own copy of the queue: slot zero is the head, slots below
    // model_len hold live words.
    logic [WIDTH-1:0]   model_words[DEPTH];
    int                 model_len      = 0;

    // Counters that other processes read at a clock edge are written with
    // nonblocking assignments, so every such reader sees the value from
    // before that edge.
    int                 outstanding    = 0;
    int                 stuck          = 0;
    int                 idle_phase     = 0;
    int                 mismatches     = 0;
    int                 results_checked = 0;
    queue_op_t          drive_op;
    queue_result_t      want;
    int                 hold_left      = 0;
    int                 results_taken  = 0;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        mismatches++;
        $display("ERROR: result %0d %s: got %0h, expected %0h",
                 results_checked, what, got, exp_val);
    endtask

    // Applies one operation to the queue copy and returns the result the
    // block must give for it. Delete removes only the oldest equal word and
    // closes the gap, so the order of the remaining words is kept.
    function automatic queue_result_t queue_apply(logic [CMD_W-1:0] op,
                                                  logic [VALUE_W-1:0] word);
        queue_result_t    r;
        logic [WIDTH-1:0] w;
        int               hit;
        r.status   = STAT_OK;
        r.data_out = '0;
        w          = word[WIDTH-1:0];
        hit        = -1;
        case (op)
            CMD_ENQ:
            begin
                if (w == '0)
                    r.status = STAT_NULL;
                else if (model_len >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    model_words[model_len] = w;
                    model_len++;
                end
            end
            CMD_DEQ:
            begin
                if (model_len == 0)
                    r.status = STAT_NULL;
                else
                begin
                    r.data_out = DOUT_W'(model_words[0]);
                    for (int i = 1; i < model_len; i++)
                        model_words[i-1] = model_words[i];
                    model_len--;
                end
            end
            CMD_DEL:
            begin
                if (w == '0)
                    r.status = STAT_NULL;
                else
                begin
                    for (int i = 0; i < model_len; i++)
                        if (hit < 0 && model_words[i] == w)
                            hit = i;
                    if (hit < 0)
                        r.status = STAT_NOTFOUND;
                    else
                    begin
                        for (int i = hit + 1; i < model_len; i++)
                            model_words[i-1] = model_words[i];
                        model_len--;
                    end
                end
            end
            default:
                r.status = STAT_NULL;
        endcase
        r.length = LEN_W'(model_len);
        return r;
    endfunction

    // Two in five words are drawn from a small pool so that deletes hit and
    // duplicates appear; the rest are full random words, nulls and extremes.
    function automatic logic [VALUE_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return word_pool[$urandom_range(POOL_SIZE - 1)];
        if (roll < 45)
            return '0;
        if (roll < 50)
        begin
            case ($urandom_range(2))
                0:       return '1;
                1:       return VALUE_W'(1);
                default: return {1'b1, {(VALUE_W - 1){1'b0}}};
            endcase
        end
        return $urandom;
    endfunction

    function automatic void push_op(logic [CMD_W-1:0] op, logic [VALUE_W-1:0] word);
        queue_op_t item;
        item.op         = op;
        item.word       = word;
        item.wait_drain = hold_for_drain;
        item.phase      = (op_backlog.size() < PHASE_SPAN) ? 0 :
                          (op_backlog.size() < 2 * PHASE_SPAN) ? 1 : 2;
        hold_for_drain  = 1'b0;
        op_backlog.push_back(item);
    endfunction

    // Driver: presents the next backlog item when the channel is free. A
    // stalled item stays on the port unchanged until it is transferred.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= '0;
            value    <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            // An item marked for a drain waits until nothing is due any more.
            // A transfer at this very edge is not yet in outstanding, hence
            // the extra check of in_valid.
            if (op_backlog.size() != 0
                && !(op_backlog[0].wait_drain && (in_valid || outstanding != 0))
                && $urandom_range(99) >= sender_idle_pct[op_backlog[0].phase])
            begin
                drive_op = op_backlog.pop_front();
                in_valid   <= 1'b1;
                cmd        <= drive_op.op;
                value      <= drive_op.word;
                idle_phase <= drive_op.phase;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls by phase, plus two long hold-offs that let the
    // block fill up and push back on its input while the driver keeps offering.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall     <= 1'b0;
            hold_left     = 0;
            results_taken = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_taken++;
                if (results_taken == 150 || results_taken == 600)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < receiver_idle_pct[idle_phase]);
        end
    end

    // Monitor: every input transfer queues its predicted result, and every
    // output transfer is checked against the oldest prediction. The output
    // side is handled first, so a result that shows up in the same cycle as
    // its own input would be flagged.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding <= 0;
            stuck       <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                    report_mismatch("arrived with nothing due", 64'(status), 64'(0));
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 64'(status), 64'(want.status));
                    if (data_out !== want.data_out)
                        report_mismatch("data_out", 64'(data_out), 64'(want.data_out));
                    if (length !== want.length)
                        report_mismatch("length", 64'(length), 64'(want.length));
                end
                results_checked <= results_checked + 1;
            end
            if (in_valid && !in_stall)
                due_results.push_back(queue_apply(cmd, value));
            outstanding <= outstanding + int'(in_valid && !in_stall)
                                       - int'(out_valid && !out_stall);
            stuck <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0 : stuck + 1;
        end
    end

    // Watchdog: a long stretch with no transfer at all means the block hung.
    initial
    begin
        wait (stuck >= STUCK_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int kind;
        int run_len;
        int roll;
        int next_drain_mark;
        bit first_seq;
        first_seq       = 1'b1;
        next_drain_mark = DRAIN_EVERY;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            word_pool[i] = $urandom;
            if (word_pool[i] == '0)
                word_pool[i] = VALUE_W'(1);
        end

        // Directed part: empty-queue dequeue and delete, null enqueue and
        // delete, the unused command code, extreme words, delete of the oldest
        // of two equal words from the middle, and delete of the sole entry.
        push_op(CMD_DEQ,  32'hFFFF_FFFF);
        push_op(CMD_DEL,  32'hDEAD_BEEF);
        push_op(CMD_ENQ,  32'h0000_0000);
        push_op(CMD_DEL,  32'h0000_0000);
        push_op(CMD_RSVD, 32'hFFFF_FFFF);
        push_op(CMD_ENQ,  32'hFFFF_FFFF);
        push_op(CMD_ENQ,  32'h0000_0001);
        push_op(CMD_ENQ,  32'h8000_0000);
        push_op(CMD_ENQ,  32'h0000_0001);
        push_op(CMD_DEL,  32'h5A5A_5A5A);
        push_op(CMD_DEL,  32'h0000_0001);
        push_op(CMD_DEQ,  32'h0000_0000);
        push_op(CMD_DEQ,  32'h7FFF_FFFF);
        push_op(CMD_DEL,  32'h0000_0001);
        push_op(CMD_DEQ,  32'h1234_5678);
        push_op(CMD_RSVD, 32'h0000_0000);

        // Random part, built from short runs: fill past full, drain past
        // empty, load-then-delete of pooled words, and mixed traffic. The
        // first run fills the queue so the full case comes early.
        while (op_backlog.size() < 16 + RANDOM_ITEMS)
        begin
            if (op_backlog.size() >= next_drain_mark)
            begin
                hold_for_drain  = 1'b1;
                next_drain_mark += DRAIN_EVERY;
            end
            kind      = first_seq ? 0 : $urandom_range(99);
            first_seq = 1'b0;
            if (kind < 15)
                repeat (DEPTH + 3)
                    push_op(CMD_ENQ, pick_word());
            else if (kind < 30)
                repeat (DEPTH + 2)
                    push_op(CMD_DEQ, $urandom);
            else if (kind < 50)
            begin
                repeat (6)
                    push_op(CMD_ENQ, word_pool[$urandom_range(POOL_SIZE - 1)]);
                repeat (8)
                    push_op(CMD_DEL, ($urandom_range(99) < 70)
                                     ? word_pool[$urandom_range(POOL_SIZE - 1)]
                                     : pick_word());
            end
            else
            begin
                run_len = $urandom_range(15, 40);
                repeat (run_len)
                begin
                    roll = $urandom_range(99);
                    if (roll < 40)
                        push_op(CMD_ENQ, pick_word());
                    else if (roll < 65)
                        push_op(CMD_DEQ, $urandom);
                    else if (roll < 95)
                        push_op(CMD_DEL, ($urandom_range(99) < 60)
                                         ? word_pool[$urandom_range(POOL_SIZE - 1)]
                                         : pick_word());
                    else
                        push_op(CMD_RSVD, $urandom);
                end
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge, when every counter of the last rising
        // edge has settled.
        while (op_backlog.size() != 0 || in_valid || outstanding > 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (due_results.size() != 0)
            report_mismatch("results never arrived", 64'(0), 64'(due_results.size()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
